/* design/scc_pkg.sv */
// Shared constants, codes and handshake structs for the sliding chunk correlation block.
package scc_pkg;

  localparam int DEF_COORD_BITS     = 12;
  localparam int DEF_MAX_CHUNK_SIZE = 1024;
  localparam int CHUNKS_PER_WINDOW  = 3;

  localparam int CFG_IDX_BITS     = 1;
  localparam int CFG_DATA_BITS    = 11;
  localparam int CHUNK_COUNT_BITS = 8;
  localparam int CHUNK_SIZE_RESET  = 16;
  localparam int CHUNK_COUNT_RESET = 80;

  localparam int R2_BITS = 17;
  localparam int Q_BITS  = 16;
  localparam logic [R2_BITS-1:0] R2_ONE = R2_BITS'(65536);

  localparam logic [CFG_IDX_BITS-1:0] REG_CHUNK_SIZE  = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_CHUNK_COUNT = CFG_IDX_BITS'(1);

  typedef enum logic [2:0] {
    OP_NSXX  = 3'd0,
    OP_SXSX  = 3'd1,
    OP_NSYY  = 3'd2,
    OP_SYSY  = 3'd3,
    OP_NSXY  = 3'd4,
    OP_SXSY  = 3'd5,
    OP_VXVY  = 3'd6,
    OP_NUMSQ = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    RES_QUOT  = 2'd0,
    RES_ONE   = 2'd1,
    RES_DEGEN = 2'd2
  } res_e;

  typedef struct packed {
    logic take;
    logic mul_start;
    logic capture;
    op_e  op;
    logic div_step;
    logic out_load;
    res_e kind;
  } scc_cmd_t;

  typedef struct packed {
    logic win_start;
    logic mul_done;
    logic degen;
    logic one;
    logic out_busy;
  } scc_status_t;

endpackage

/* design/scc_mul.sv */
// Radix-2 shift-and-add multiplier that produces one product bit position per cycle.
module scc_mul #(
  parameter int W = 48
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [W-1:0]   a_i,
  input  logic [W-1:0]   b_i,
  output logic           done_o,
  output logic [2*W-1:0] prod_o
);

  localparam int CW = (W > 1) ? $clog2(W) : 1;

  logic [2*W-1:0] a_q, p_q;
  logic [W-1:0]   b_q;
  logic [CW-1:0]  cnt_q;
  logic           busy_q, done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == CW'(W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= {{W{1'b0}}, a_i};
      b_q <= b_i;
      p_q <= '0;
    end else if (busy_q) begin
      if (b_q[0]) begin
        p_q <= p_q + a_q;
      end
      a_q <= {a_q[2*W-2:0], 1'b0};
      b_q <= {1'b0, b_q[W-1:1]};
    end
  end

  assign done_o = done_q;
  assign prod_o = p_q;

endmodule

/* design/scc_dp.sv */
// Datapath: configuration, chunk accumulators, previous-chunk store, window math and output register.
module scc_dp #(
  parameter int COORD_BITS     = scc_pkg::DEF_COORD_BITS,
  parameter int MAX_CHUNK_SIZE = scc_pkg::DEF_MAX_CHUNK_SIZE
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  input  logic [scc_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  logic [scc_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  input  logic                               in_accept_i,
  input  logic [COORD_BITS-1:0]              x_i,
  input  logic [COORD_BITS-1:0]              y_i,
  input  logic                               first_i,
  input  scc_pkg::scc_cmd_t                  cmd_i,
  output scc_pkg::scc_status_t               st_o,
  input  logic                               out_ready_i,
  output logic                               out_valid_o,
  output logic [scc_pkg::R2_BITS-1:0]        r_squared_o,
  output logic [scc_pkg::CHUNK_COUNT_BITS-1:0] window_index_o,
  output logic                               degenerate_o
);

  localparam int LMAX = $clog2(MAX_CHUNK_SIZE);
  localparam int SXW  = COORD_BITS + LMAX;
  localparam int SQW  = 2 * COORD_BITS + LMAX;
  localparam int WXW  = SXW + 2;
  localparam int WQW  = SQW + 2;
  localparam int NW   = LMAX + 2;
  localparam int MW   = 2 * WXW;
  localparam int PW   = 2 * MW;
  localparam int CSW  = LMAX + 1;
  localparam int CCW  = scc_pkg::CHUNK_COUNT_BITS;
  localparam int QW   = scc_pkg::Q_BITS;

  // Configuration registers.
  logic [scc_pkg::CFG_DATA_BITS-1:0] chunk_size_q;
  logic [CCW-1:0]                    chunk_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_size_q  <= scc_pkg::CFG_DATA_BITS'(scc_pkg::CHUNK_SIZE_RESET);
      chunk_count_q <= CCW'(scc_pkg::CHUNK_COUNT_RESET);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        scc_pkg::REG_CHUNK_SIZE:  chunk_size_q  <= cfg_data_i;
        scc_pkg::REG_CHUNK_COUNT: chunk_count_q <= cfg_data_i[CCW-1:0];
        default: ;
      endcase
    end
  end

  // Effective chunk size: zero acts as one, large values saturate.
  logic [CSW-1:0] cs;
  always_comb begin
    if (chunk_size_q == '0) begin
      cs = CSW'(1);
    end else if (int'(chunk_size_q) > MAX_CHUNK_SIZE) begin
      cs = CSW'(MAX_CHUNK_SIZE);
    end else begin
      cs = CSW'(chunk_size_q);
    end
  end

  // Chunk accumulators and counters.
  logic [SXW-1:0]  acc_x_q, acc_y_q;
  logic [SQW-1:0]  acc_xx_q, acc_yy_q, acc_xy_q;
  logic [LMAX-1:0] pic_q;
  logic [CCW-1:0]  ci_q;

  // Previous two chunks, older one at index 0.
  logic [SXW-1:0] p_x_q [2];
  logic [SXW-1:0] p_y_q [2];
  logic [SQW-1:0] p_xx_q [2];
  logic [SQW-1:0] p_yy_q [2];
  logic [SQW-1:0] p_xy_q [2];

  logic [SXW-1:0]  ax, ay, nx, ny;
  logic [SQW-1:0]  axx, ayy, axy, nxx, nyy, nxy;
  logic [2*COORD_BITS-1:0] pxx, pyy, pxy;
  logic [LMAX-1:0] pic_e;
  logic [CCW-1:0]  ci_e;
  logic [CSW-1:0]  pic_inc;
  logic            active, close, win;

  always_comb begin
    ax    = first_i ? '0 : acc_x_q;
    ay    = first_i ? '0 : acc_y_q;
    axx   = first_i ? '0 : acc_xx_q;
    ayy   = first_i ? '0 : acc_yy_q;
    axy   = first_i ? '0 : acc_xy_q;
    pic_e = first_i ? '0 : pic_q;
    ci_e  = first_i ? '0 : ci_q;
    pxx   = x_i * x_i;
    pyy   = y_i * y_i;
    pxy   = x_i * y_i;
    nx    = ax + SXW'(x_i);
    ny    = ay + SXW'(y_i);
    nxx   = axx + SQW'(pxx);
    nyy   = ayy + SQW'(pyy);
    nxy   = axy + SQW'(pxy);
    pic_inc = {1'b0, pic_e} + CSW'(1);
    active  = ci_e < chunk_count_q;
    close   = active && (pic_inc >= cs);
    win     = close && (ci_e >= CCW'(scc_pkg::CHUNKS_PER_WINDOW - 1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_x_q  <= '0;
      acc_y_q  <= '0;
      acc_xx_q <= '0;
      acc_yy_q <= '0;
      acc_xy_q <= '0;
      pic_q    <= '0;
      ci_q     <= '0;
    end else if (in_accept_i) begin
      if (close) begin
        acc_x_q  <= '0;
        acc_y_q  <= '0;
        acc_xx_q <= '0;
        acc_yy_q <= '0;
        acc_xy_q <= '0;
        pic_q    <= '0;
        ci_q     <= ci_e + CCW'(1);
      end else if (active) begin
        acc_x_q  <= nx;
        acc_y_q  <= ny;
        acc_xx_q <= nxx;
        acc_yy_q <= nyy;
        acc_xy_q <= nxy;
        pic_q    <= pic_inc[LMAX-1:0];
        ci_q     <= ci_e;
      end else begin
        acc_x_q  <= ax;
        acc_y_q  <= ay;
        acc_xx_q <= axx;
        acc_yy_q <= ayy;
        acc_xy_q <= axy;
        pic_q    <= pic_e;
        ci_q     <= ci_e;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept_i && close) begin
      p_x_q[0]  <= p_x_q[1];
      p_y_q[0]  <= p_y_q[1];
      p_xx_q[0] <= p_xx_q[1];
      p_yy_q[0] <= p_yy_q[1];
      p_xy_q[0] <= p_xy_q[1];
      p_x_q[1]  <= nx;
      p_y_q[1]  <= ny;
      p_xx_q[1] <= nxx;
      p_yy_q[1] <= nyy;
      p_xy_q[1] <= nxy;
    end
  end

  // Window sums, latched when a chunk closes with a full window behind it.
  logic [NW-1:0]  wn_q;
  logic [WXW-1:0] wsx_q, wsy_q;
  logic [WQW-1:0] wsxx_q, wsyy_q, wsxy_q;
  logic [CCW-1:0] wi_q;

  always_ff @(posedge clk_i) begin
    if (in_accept_i && win) begin
      wn_q   <= NW'(cs) * NW'(scc_pkg::CHUNKS_PER_WINDOW);
      wsx_q  <= WXW'(p_x_q[0]) + WXW'(p_x_q[1]) + WXW'(nx);
      wsy_q  <= WXW'(p_y_q[0]) + WXW'(p_y_q[1]) + WXW'(ny);
      wsxx_q <= WQW'(p_xx_q[0]) + WQW'(p_xx_q[1]) + WQW'(nxx);
      wsyy_q <= WQW'(p_yy_q[0]) + WQW'(p_yy_q[1]) + WQW'(nyy);
      wsxy_q <= WQW'(p_xy_q[0]) + WQW'(p_xy_q[1]) + WQW'(nxy);
      wi_q   <= ci_e - CCW'(scc_pkg::CHUNKS_PER_WINDOW - 1);
    end
  end

  // Variance, numerator and restoring divider registers.
  logic [MW-1:0] t_q, vx_q, vy_q, num_q;
  logic [PW-1:0] den_q;
  logic [PW:0]   rem_q, rem2;
  logic [QW-1:0] q_q;
  logic [MW-1:0] plo;

  // Shared multiplier and its operand selection.
  logic [MW-1:0] mul_a, mul_b;
  logic [PW-1:0] prod;
  logic          mul_done;

  always_comb begin
    case (cmd_i.op)
      scc_pkg::OP_NSXX: begin mul_a = MW'(wn_q);  mul_b = MW'(wsxx_q); end
      scc_pkg::OP_SXSX: begin mul_a = MW'(wsx_q); mul_b = MW'(wsx_q);  end
      scc_pkg::OP_NSYY: begin mul_a = MW'(wn_q);  mul_b = MW'(wsyy_q); end
      scc_pkg::OP_SYSY: begin mul_a = MW'(wsy_q); mul_b = MW'(wsy_q);  end
      scc_pkg::OP_NSXY: begin mul_a = MW'(wn_q);  mul_b = MW'(wsxy_q); end
      scc_pkg::OP_SXSY: begin mul_a = MW'(wsx_q); mul_b = MW'(wsy_q);  end
      scc_pkg::OP_VXVY: begin mul_a = vx_q;       mul_b = vy_q;        end
      default:          begin mul_a = num_q;      mul_b = num_q;       end
    endcase
  end

  scc_mul #(.W(MW)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  assign plo  = prod[MW-1:0];
  assign rem2 = {rem_q[PW-1:0], 1'b0};

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      case (cmd_i.op)
        scc_pkg::OP_NSXX, scc_pkg::OP_NSYY, scc_pkg::OP_NSXY: t_q <= plo;
        scc_pkg::OP_SXSX: vx_q <= t_q - plo;
        scc_pkg::OP_SYSY: vy_q <= t_q - plo;
        scc_pkg::OP_SXSY: num_q <= (t_q >= plo) ? t_q - plo : plo - t_q;
        scc_pkg::OP_VXVY: den_q <= prod;
        default: begin
          rem_q <= {1'b0, prod};
          q_q   <= '0;
        end
      endcase
    end else if (cmd_i.div_step) begin
      if (rem2 >= {1'b0, den_q}) begin
        rem_q <= rem2 - {1'b0, den_q};
        q_q   <= {q_q[QW-2:0], 1'b1};
      end else begin
        rem_q <= rem2;
        q_q   <= {q_q[QW-2:0], 1'b0};
      end
    end
  end

  // Output register.
  logic                        out_valid_q;
  logic [scc_pkg::R2_BITS-1:0] r2_q;
  logic [CCW-1:0]              oidx_q;
  logic                        dg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      oidx_q <= wi_q;
      case (cmd_i.kind)
        scc_pkg::RES_QUOT: begin
          r2_q <= scc_pkg::R2_BITS'(q_q);
          dg_q <= 1'b0;
        end
        scc_pkg::RES_DEGEN: begin
          r2_q <= scc_pkg::R2_ONE;
          dg_q <= 1'b1;
        end
        default: begin
          r2_q <= scc_pkg::R2_ONE;
          dg_q <= 1'b0;
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign r_squared_o    = r2_q;
  assign window_index_o = oidx_q;
  assign degenerate_o   = dg_q;

  assign st_o.win_start = in_accept_i && win;
  assign st_o.mul_done  = mul_done;
  assign st_o.degen     = (vx_q == '0) || (vy_q == '0);
  assign st_o.one       = rem_q >= {1'b0, den_q};
  assign st_o.out_busy  = out_valid_q && !out_ready_i;

endmodule

/* design/scc_ctrl.sv */
// Controller that sequences the window multiplies, the divider and the output load.
module scc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  scc_pkg::scc_status_t st_i,
  output scc_pkg::scc_cmd_t    cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MSTART = 3'd1;
  localparam logic [2:0] S_MWAIT  = 3'd2;
  localparam logic [2:0] S_CHECK  = 3'd3;
  localparam logic [2:0] S_DIV    = 3'd4;
  localparam logic [2:0] S_OUT    = 3'd5;

  localparam int DCW = $clog2(scc_pkg::Q_BITS);

  logic [2:0]        state_q, state_d;
  scc_pkg::op_e      op_q, op_d;
  scc_pkg::res_e     kind_q, kind_d;
  logic [DCW-1:0]    cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    kind_d  = kind_q;
    cnt_d   = cnt_q;
    cmd_o           = '0;
    cmd_o.op        = op_q;
    cmd_o.kind      = kind_q;
    case (state_q)
      S_IDLE: begin
        cmd_o.take = 1'b1;
        if (st_i.win_start) begin
          op_d    = scc_pkg::OP_NSXX;
          state_d = S_MSTART;
        end
      end
      S_MSTART: begin
        cmd_o.mul_start = 1'b1;
        state_d         = S_MWAIT;
      end
      S_MWAIT: begin
        if (st_i.mul_done) begin
          cmd_o.capture = 1'b1;
          if (op_q == scc_pkg::OP_SXSY && st_i.degen) begin
            kind_d  = scc_pkg::RES_DEGEN;
            state_d = S_OUT;
          end else if (op_q == scc_pkg::OP_NUMSQ) begin
            state_d = S_CHECK;
          end else begin
            op_d    = scc_pkg::op_e'(3'(op_q) + 3'd1);
            state_d = S_MSTART;
          end
        end
      end
      S_CHECK: begin
        cnt_d = '0;
        if (st_i.one) begin
          kind_d  = scc_pkg::RES_ONE;
          state_d = S_OUT;
        end else begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + DCW'(1);
        if (cnt_q == DCW'(scc_pkg::Q_BITS - 1)) begin
          kind_d  = scc_pkg::RES_QUOT;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!st_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= scc_pkg::OP_NSXX;
      kind_q  <= scc_pkg::RES_QUOT;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      kind_q  <= kind_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

/* design/sliding_chunk_correlation.sv */
// Sliding three-chunk squared correlation of contour points: top level.
// Points are taken one per cycle and summed per chunk; when a chunk closes with two
// earlier chunks of the same contour behind it, the block computes r^2 of those three
// chunks as Q1.16 (65536 = 1.0, floor) and holds it in an output register while the
// next contour points keep flowing. That closing point blocks input for the window
// computation: eight products on one shift-and-add multiplier, then one compare and
// sixteen divide steps (a zero variance skips the last two products and the divide),
// and until the output register is free to load. Configuration writes are taken at any time
// with ready held high and should only be issued while the block is idle.
module sliding_chunk_correlation #(
  parameter int COORD_BITS     = scc_pkg::DEF_COORD_BITS,
  parameter int MAX_CHUNK_SIZE = scc_pkg::DEF_MAX_CHUNK_SIZE
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [scc_pkg::CFG_IDX_BITS-1:0]     cfg_index_i,
  input  logic [scc_pkg::CFG_DATA_BITS-1:0]    cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [COORD_BITS-1:0]                x_i,
  input  logic [COORD_BITS-1:0]                y_i,
  input  logic                                 first_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [scc_pkg::R2_BITS-1:0]          r_squared_o,
  output logic [scc_pkg::CHUNK_COUNT_BITS-1:0] window_index_o,
  output logic                                 degenerate_o
);

  scc_pkg::scc_cmd_t    cmd;
  scc_pkg::scc_status_t st;
  logic                 in_accept;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = cmd.take;
  assign in_accept   = in_valid_i && cmd.take;

  scc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .st_i   (st),
    .cmd_o  (cmd)
  );

  scc_dp #(
    .COORD_BITS     (COORD_BITS),
    .MAX_CHUNK_SIZE (MAX_CHUNK_SIZE)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_accept_i    (in_accept),
    .x_i            (x_i),
    .y_i            (y_i),
    .first_i        (first_i),
    .cmd_i          (cmd),
    .st_o           (st),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .r_squared_o    (r_squared_o),
    .window_index_o (window_index_o),
    .degenerate_o   (degenerate_o)
  );

  // A closing chunk that starts a window must stall the input side.
  a_win_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st.win_start |=> !in_ready_o)
    else $error("input still ready after a window started");

  // A loaded result is presented on the next cycle.
  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |=> out_valid_o)
    else $error("loaded result not presented");

  // A degenerate window always reports exactly 1.0.
  a_degen_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && degenerate_o) |-> (r_squared_o == scc_pkg::R2_ONE))
    else $error("degenerate result is not 1.0");

  // The squared correlation never exceeds 1.0.
  a_r2_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (r_squared_o <= scc_pkg::R2_ONE))
    else $error("r squared above 1.0");

endmodule
